### rtl/core/swm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and constants of the waveform measurement unit.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int unsigned MAX_SAMPLES_DEF = 8192;
    localparam int unsigned SAMPLE_BITS_DEF = 12;

    // Register reset values
    localparam logic [11:0] UPPER_RST = 12'd2148;
    localparam logic [11:0] LOWER_RST = 12'd1948;
    localparam logic [11:0] CENTRE_RST = 12'd2048;
    localparam logic [12:0] PRETRIG_RST = 13'd151;

    // Register indexes
    localparam logic [1:0] REG_UPPER   = 2'd0;
    localparam logic [1:0] REG_LOWER   = 2'd1;
    localparam logic [1:0] REG_CENTRE  = 2'd2;
    localparam logic [1:0] REG_PRETRIG = 2'd3;

    // Hysteresis level
    typedef enum logic [1:0] {
        LVL_LOW     = 2'd0,
        LVL_HIGH    = 2'd1,
        LVL_UNKNOWN = 2'd2
    } t_level;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_SQRT,
        BK_OUT
    } t_bk_state;

    // Finished capture totals handed from front to back
    typedef struct packed {
        logic [13:0] count;
        logic [11:0] max_v;
        logic [11:0] min_v;
        logic [24:0] sum;
        logic [37:0] sq_sum;
        logic [13:0] rise_total;
        logic [13:0] fall_total;
        logic [13:0] low_sum;
        logic [13:0] high_sum;
        logic [12:0] rise_pos;
        logic [12:0] fall_pos;
    } t_capture;

    // Result record
    typedef struct packed {
        logic [11:0] max_level;
        logic [11:0] min_level;
        logic [11:0] mean_level;
        logic [11:0] mid_level;
        logic [11:0] peak_to_peak;
        logic [23:0] mean_square;
        logic [11:0] rms_level;
        logic [13:0] edge_count;
        logic [12:0] high_time_avg;
        logic [12:0] low_time_avg;
        logic [12:0] rise_position;
        logic [12:0] fall_position;
    } t_result;

endpackage
`default_nettype wire

### rtl/core/swm_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swm_front
// Per-sample accumulation: extremes, sums, hysteresis edges and dwell times.
// ----------------------------------------------------------------------------
module swm_front import swm_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [11:0] i_sample,
    input  wire logic        i_last,
    input  wire logic [11:0] i_upper,
    input  wire logic [11:0] i_lower,
    input  wire logic [11:0] i_centre,
    input  wire logic [12:0] i_pretrig,
    output logic             o_cap_valid,
    input  wire logic        i_cap_ready,
    output t_capture         o_cap
);
    localparam int unsigned IDXW = $clog2(MAX_SAMPLES_DEF + 1);
    localparam logic [11:0] SMASK = 12'((1 << SAMPLE_BITS_DEF) - 1);

    logic [IDXW-1:0] r_idx;
    logic [11:0] r_max, r_min;
    logic [24:0] r_sum;
    logic [37:0] r_sq;
    t_level r_lvl;
    logic [13:0] r_dwell, r_low_sum, r_high_sum, r_rises, r_falls;
    logic [12:0] r_rpos, r_fpos;
    logic r_cap_valid;
    t_capture r_cap;

    logic [11:0] s, d;
    logic [23:0] d2;
    logic take, acc;
    logic [13:0] dw;

    // Queue slot for one finished capture
    assign o_ready = !r_cap_valid || i_cap_ready;
    assign acc = i_valid && o_ready;
    assign s = i_sample & SMASK;
    assign take = r_idx < IDXW'(MAX_SAMPLES_DEF);
    assign d = (s >= i_centre) ? s - i_centre : i_centre - s;
    assign d2 = d * d;
    assign dw = (r_lvl == LVL_UNKNOWN) ? 14'd0 : r_dwell + 14'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_valid <= 1'b0;
        end else if (acc && i_last) begin
            r_cap_valid <= 1'b1;
        end else if (i_cap_ready) begin
            r_cap_valid <= 1'b0;
        end
    end

    // Running capture state
    always_ff @(posedge i_clk) begin
        logic [11:0] n_max, n_min;
        logic [24:0] n_sum;
        logic [37:0] n_sq;
        t_level n_lvl;
        logic [13:0] n_dwell, n_low, n_high, n_rises, n_falls;
        logic [12:0] n_rpos, n_fpos;
        logic [IDXW-1:0] n_idx;
        n_max = r_max; n_min = r_min; n_sum = r_sum; n_sq = r_sq;
        n_lvl = r_lvl; n_dwell = r_dwell; n_low = r_low_sum; n_high = r_high_sum;
        n_rises = r_rises; n_falls = r_falls; n_rpos = r_rpos; n_fpos = r_fpos;
        n_idx = r_idx;
        if (take) begin
            if (s > r_max) n_max = s;
            if (s < r_min) n_min = s;
            n_sum = r_sum + 25'(s);
            n_sq = r_sq + 38'(d2);
            n_dwell = dw;
            if (s > i_upper) begin
                if (r_lvl == LVL_LOW) begin
                    n_low = r_low_sum + dw;
                    n_dwell = 14'd0;
                    n_rises = r_rises + 14'd1;
                    if (r_rpos < i_pretrig) n_rpos = 13'(r_idx);
                end
                n_lvl = LVL_HIGH;
            end else if (s < i_lower) begin
                if (r_lvl == LVL_HIGH) begin
                    n_high = r_high_sum + dw;
                    n_dwell = 14'd0;
                    n_falls = r_falls + 14'd1;
                    if (r_fpos < i_pretrig) n_fpos = 13'(r_idx);
                end
                n_lvl = LVL_LOW;
            end
            n_idx = r_idx + 1'b1;
        end
        if (acc && i_last) begin
            r_cap <= '{count: 14'(n_idx), max_v: n_max, min_v: n_min, sum: n_sum,
                       sq_sum: n_sq, rise_total: n_rises, fall_total: n_falls,
                       low_sum: n_low, high_sum: n_high, rise_pos: n_rpos,
                       fall_pos: n_fpos};
        end
        if (!i_rst_n || (acc && i_last)) begin
            r_idx <= '0; r_max <= '0; r_min <= SMASK; r_sum <= '0; r_sq <= '0;
            r_lvl <= LVL_UNKNOWN; r_dwell <= '0; r_low_sum <= '0; r_high_sum <= '0;
            r_rises <= '0; r_falls <= '0; r_rpos <= '0; r_fpos <= '0;
        end else if (acc) begin
            r_idx <= n_idx; r_max <= n_max; r_min <= n_min; r_sum <= n_sum;
            r_sq <= n_sq; r_lvl <= n_lvl; r_dwell <= n_dwell; r_low_sum <= n_low;
            r_high_sum <= n_high; r_rises <= n_rises; r_falls <= n_falls;
            r_rpos <= n_rpos; r_fpos <= n_fpos;
        end
    end

    assign o_cap_valid = r_cap_valid;
    assign o_cap = r_cap;

`ifndef ASSERT_OFF
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= IDXW'(MAX_SAMPLES_DEF)) else $error("sample index overran");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_last |=> r_idx == '0 && r_lvl == LVL_UNKNOWN)
        else $error("capture not cleared");
    a_minmax: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx != '0 |-> r_max >= r_min) else $error("max below min");
`endif
endmodule
`default_nettype wire

### rtl/core/swm_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swm_back
// Per-capture finish: shared restoring divider, bit-serial square root,
// and a one-entry result register.
// ----------------------------------------------------------------------------
module swm_back import swm_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_cap_valid,
    output logic       o_cap_ready,
    input  wire t_capture i_cap,
    output logic       o_res_valid,
    input  wire logic  i_res_ready,
    output t_result    o_res
);
    // Divisions run in this order
    localparam logic [1:0] DIV_MEAN = 2'd0;
    localparam logic [1:0] DIV_MSQ  = 2'd1;
    localparam logic [1:0] DIV_HIGH = 2'd2;
    localparam logic [1:0] DIV_LOW  = 2'd3;

    t_bk_state r_st, n_st;
    t_capture r_c;
    logic [1:0] r_op;
    logic [5:0] r_bit;
    logic [37:0] r_quo;
    logic [38:0] r_rem;
    logic [23:0] r_msq, r_sq_v;
    logic [11:0] r_mean;
    logic [12:0] r_havg, r_lavg;
    logic [23:0] r_root, r_sbit;
    t_result r_res;
    logic r_res_valid;

    logic [37:0] dividend;
    logic [13:0] divisor;
    logic [38:0] trial;
    logic div_done, sq_done;
    logic [24:0] rb;

    always_comb begin
        case (r_op)
            DIV_MEAN: begin dividend = 38'(r_c.sum); divisor = r_c.count; end
            DIV_MSQ:  begin dividend = r_c.sq_sum;   divisor = r_c.count; end
            DIV_HIGH: begin dividend = 38'(r_c.high_sum); divisor = r_c.fall_total; end
            default:  begin dividend = 38'(r_c.low_sum);  divisor = r_c.rise_total; end
        endcase
        if (divisor == '0 && r_op < DIV_HIGH) divisor = 14'd1;
    end

    assign trial = {r_rem[37:0], dividend[r_bit]} - 39'(divisor);
    assign div_done = (r_bit == 6'd0);
    assign rb = 25'(r_root) + 25'(r_sbit);
    assign sq_done = (r_sbit == 24'd0);
    assign o_cap_ready = (r_st == BK_IDLE);

    always_comb begin
        n_st = r_st;
        case (r_st)
            BK_IDLE: if (i_cap_valid) n_st = BK_DIV;
            BK_DIV:  if (div_done && r_op == DIV_LOW) n_st = BK_SQRT;
            BK_SQRT: if (sq_done) n_st = BK_OUT;
            BK_OUT:  if (!r_res_valid || i_res_ready) n_st = BK_IDLE;
            default: n_st = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= BK_IDLE;
        else r_st <= n_st;
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        logic [37:0] q;
        logic [38:0] rm;
        q = {r_quo[36:0], !trial[38]};
        rm = trial[38] ? {r_rem[37:0], dividend[r_bit]} : trial;
        case (r_st)
            BK_IDLE: begin
                r_c <= i_cap; r_op <= DIV_MEAN; r_bit <= 6'd37;
                r_quo <= '0; r_rem <= '0;
            end
            BK_DIV: begin
                r_bit <= r_bit - 6'd1;
                r_quo <= q; r_rem <= rm;
                if (div_done) begin
                    case (r_op)
                        DIV_MEAN: r_mean <= q[11:0];
                        DIV_MSQ:  begin r_msq <= q[23:0]; r_sq_v <= q[23:0]; end
                        DIV_HIGH: r_havg <= (divisor == '0) ? 13'd0 : q[12:0];
                        default:  r_lavg <= (divisor == '0) ? 13'd0 : q[12:0];
                    endcase
                    r_op <= r_op + 2'd1; r_bit <= 6'd37;
                    r_quo <= '0; r_rem <= '0;
                    r_root <= '0; r_sbit <= 24'h400000;
                end
            end
            BK_SQRT: begin
                // The step bit has run out in the last cycle; the root is final
                if (!sq_done) begin
                    if (25'(r_sq_v) >= rb) begin
                        r_sq_v <= r_sq_v - rb[23:0];
                        r_root <= (r_root >> 1) + r_sbit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_sbit <= r_sbit >> 2;
                end
            end
            default: ;
        endcase
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (r_st == BK_OUT && (!r_res_valid || i_res_ready)) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
        if (r_st == BK_OUT && (!r_res_valid || i_res_ready)) begin
            r_res <= '{max_level: r_c.max_v, min_level: r_c.min_v, mean_level: r_mean,
                mid_level: 12'((13'(r_c.max_v) + 13'(r_c.min_v)) >> 1),
                peak_to_peak: (r_c.max_v >= r_c.min_v) ? r_c.max_v - r_c.min_v : 12'd0,
                mean_square: r_msq, rms_level: r_root[11:0],
                edge_count: r_c.rise_total + r_c.fall_total,
                high_time_avg: r_havg, low_time_avg: r_lavg,
                rise_position: r_c.rise_pos, fall_position: r_c.fall_pos};
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res = r_res;

`ifndef ASSERT_OFF
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cap_valid && o_cap_ready |=> r_st == BK_DIV) else $error("capture lost");
    a_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == BK_OUT |-> r_root[23:12] == '0) else $error("root too wide");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && !i_res_ready |=> $stable(r_res)) else $error("result changed");
`endif
endmodule
`default_nettype wire

### rtl/core/scope_waveform_measurement_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scope_waveform_measurement_unit
// Capture statistics and hysteresis edge timing over ADC samples.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle. When the sample flagged last arrives the
// finished totals move to a back end that runs four 38-step restoring
// divisions and a 12-step square root before the result is registered. The
// next capture keeps streaming meanwhile, and the front stalls only if a
// second capture ends before the back end has finished the first. Samples
// past the first 8192 of a capture are ignored.
module scope_waveform_measurement_unit import swm_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        push,
    output logic             full,
    input  wire logic [11:0] i_sample,
    input  wire logic        i_last_sample,
    output logic             empty,
    input  wire logic        pop,
    output logic [11:0]      o_max_level,
    output logic [11:0]      o_min_level,
    output logic [11:0]      o_mean_level,
    output logic [11:0]      o_mid_level,
    output logic [11:0]      o_peak_to_peak,
    output logic [23:0]      o_mean_square,
    output logic [11:0]      o_rms_level,
    output logic [13:0]      o_edge_count,
    output logic [12:0]      o_high_time_avg,
    output logic [12:0]      o_low_time_avg,
    output logic [12:0]      o_rise_position,
    output logic [12:0]      o_fall_position
);
    logic [11:0] r_upper, r_lower, r_centre;
    logic [12:0] r_pretrig;
    logic ready, cap_valid, cap_ready, res_valid;
    t_capture cap;
    t_result res;

    assign pready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper <= UPPER_RST; r_lower <= LOWER_RST;
            r_centre <= CENTRE_RST; r_pretrig <= PRETRIG_RST;
        end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
            case (paddr[3:2])
                REG_UPPER:   r_upper <= pwdata[11:0];
                REG_LOWER:   r_lower <= pwdata[11:0];
                REG_CENTRE:  r_centre <= pwdata[11:0];
                REG_PRETRIG: r_pretrig <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_UPPER:   prdata = {20'd0, r_upper};
            REG_LOWER:   prdata = {20'd0, r_lower};
            REG_CENTRE:  prdata = {20'd0, r_centre};
            REG_PRETRIG: prdata = {19'd0, r_pretrig};
            default:     prdata = '0;
        endcase
    end

    swm_front u_front (
        .i_clk, .i_rst_n, .i_valid(push), .o_ready(ready),
        .i_sample, .i_last(i_last_sample),
        .i_upper(r_upper), .i_lower(r_lower), .i_centre(r_centre),
        .i_pretrig(r_pretrig),
        .o_cap_valid(cap_valid), .i_cap_ready(cap_ready), .o_cap(cap)
    );

    swm_back u_back (
        .i_clk, .i_rst_n, .i_cap_valid(cap_valid), .o_cap_ready(cap_ready),
        .i_cap(cap), .o_res_valid(res_valid), .i_res_ready(pop), .o_res(res)
    );

    assign full = !ready;
    assign empty = !res_valid;
    assign o_max_level = res.max_level;
    assign o_min_level = res.min_level;
    assign o_mean_level = res.mean_level;
    assign o_mid_level = res.mid_level;
    assign o_peak_to_peak = res.peak_to_peak;
    assign o_mean_square = res.mean_square;
    assign o_rms_level = res.rms_level;
    assign o_edge_count = res.edge_count;
    assign o_high_time_avg = res.high_time_avg;
    assign o_low_time_avg = res.low_time_avg;
    assign o_rise_position = res.rise_position;
    assign o_fall_position = res.fall_position;
endmodule
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the waveform measurement unit: captures of random
// ADC samples are streamed in, a cycle-free predictor computes the statistics
// and edge timing of every finished capture, and each result transfer is
// compared field by field. Thresholds, centre and pretrigger are changed
// between phases.
// ----------------------------------------------------------------------------
module tb;
    import swm_pkg::*;

    localparam int unsigned CAP_LIMIT = MAX_SAMPLES_DEF;
    localparam int unsigned DRAIN_CYCLES = 400;

    // Capture statistics predictor and store of expected measurements
    class capture_scoreboard;
        logic [11:0] upper_thr, lower_thr, centre;
        logic [12:0] pretrig;
        int unsigned n_taken;
        logic [11:0] peak_hi, peak_lo;
        longint unsigned level_sum, dev_sq_sum;
        t_level lvl;
        logic [13:0] dwell, low_dwell_sum, high_dwell_sum, rises, falls;
        logic [12:0] rise_idx, fall_idx;
        t_result measurements[$];
        int unsigned errors;

        function new();
            upper_thr = UPPER_RST;
            lower_thr = LOWER_RST;
            centre = CENTRE_RST;
            pretrig = PRETRIG_RST;
            errors = 0;
            restart();
        endfunction

        function void restart();
            n_taken = 0;
            peak_hi = '0;
            peak_lo = '1;
            level_sum = 0;
            dev_sq_sum = 0;
            lvl = LVL_UNKNOWN;
            dwell = '0;
            low_dwell_sum = '0;
            high_dwell_sum = '0;
            rises = '0;
            falls = '0;
            rise_idx = '0;
            fall_idx = '0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_UPPER: upper_thr = val[11:0];
                REG_LOWER: lower_thr = val[11:0];
                REG_CENTRE: centre = val[11:0];
                default: pretrig = val[12:0];
            endcase
        endfunction

        function logic [11:0] floor_sqrt(logic [23:0] v);
            logic [11:0] r;
            logic [12:0] t;
            r = '0;
            for (int b = 11; b >= 0; b--) begin
                t = {1'b0, r} | (13'd1 << b);
                if (t * t <= v) r = t[11:0];
            end
            return r;
        endfunction

        // Accepted sample transfer
        function void note_sample(logic [11:0] s, logic last);
            int unsigned dev, cnt;
            longint unsigned msq;
            t_result r;
            if (n_taken < CAP_LIMIT) begin
                if (s > peak_hi) peak_hi = s;
                if (s < peak_lo) peak_lo = s;
                level_sum += s;
                dev = (s >= centre) ? s - centre : centre - s;
                dev_sq_sum += longint'(dev) * dev;
                dwell = (lvl == LVL_UNKNOWN) ? 14'd0 : dwell + 14'd1;
                if (s > upper_thr) begin
                    if (lvl == LVL_LOW) begin
                        low_dwell_sum += dwell;
                        dwell = '0;
                        rises++;
                        if (rise_idx < pretrig) rise_idx = n_taken[12:0];
                    end
                    lvl = LVL_HIGH;
                end else if (s < lower_thr) begin
                    if (lvl == LVL_HIGH) begin
                        high_dwell_sum += dwell;
                        dwell = '0;
                        falls++;
                        if (fall_idx < pretrig) fall_idx = n_taken[12:0];
                    end
                    lvl = LVL_LOW;
                end
                n_taken++;
            end
            if (!last) return;
            cnt = (n_taken != 0) ? n_taken : 1;
            msq = dev_sq_sum / cnt;
            r.max_level = peak_hi;
            r.min_level = peak_lo;
            r.mean_level = 12'(level_sum / cnt);
            r.mid_level = 12'((13'(peak_hi) + 13'(peak_lo)) >> 1);
            r.peak_to_peak = (peak_hi >= peak_lo) ? peak_hi - peak_lo : 12'd0;
            r.mean_square = msq[23:0];
            r.rms_level = floor_sqrt(msq[23:0]);
            r.edge_count = rises + falls;
            r.high_time_avg = (falls != 0) ? 13'(high_dwell_sum / falls) : 13'd0;
            r.low_time_avg = (rises != 0) ? 13'(low_dwell_sum / rises) : 13'd0;
            r.rise_position = rise_idx;
            r.fall_position = fall_idx;
            measurements.push_back(r);
            restart();
        endfunction

        function void cmp(string name, logic [23:0] e, logic [23:0] a);
            if (e !== a) begin
                $error("%s: expected %0d, got %0d", name, e, a);
                errors++;
            end
        endfunction

        // Accepted result transfer
        function void check_result(t_result a);
            t_result e;
            if (measurements.size() == 0) begin
                $error("result transfer with no capture pending");
                errors++;
                return;
            end
            e = measurements.pop_front();
            cmp("max_level", e.max_level, a.max_level);
            cmp("min_level", e.min_level, a.min_level);
            cmp("mean_level", e.mean_level, a.mean_level);
            cmp("mid_level", e.mid_level, a.mid_level);
            cmp("peak_to_peak", e.peak_to_peak, a.peak_to_peak);
            cmp("mean_square", e.mean_square, a.mean_square);
            cmp("rms_level", e.rms_level, a.rms_level);
            cmp("edge_count", e.edge_count, a.edge_count);
            cmp("high_time_avg", e.high_time_avg, a.high_time_avg);
            cmp("low_time_avg", e.low_time_avg, a.low_time_avg);
            cmp("rise_position", e.rise_position, a.rise_position);
            cmp("fall_position", e.fall_position, a.fall_position);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        push, full, empty, pop;
    logic [11:0] i_sample;
    logic        i_last_sample;
    t_result     dut_res;
    capture_scoreboard sb;
    bit          hold_req = 1'b0;

    always #1 i_clk = ~i_clk;

    scope_waveform_measurement_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .push(push), .full(full), .i_sample(i_sample), .i_last_sample(i_last_sample),
        .empty(empty), .pop(pop),
        .o_max_level(dut_res.max_level), .o_min_level(dut_res.min_level),
        .o_mean_level(dut_res.mean_level), .o_mid_level(dut_res.mid_level),
        .o_peak_to_peak(dut_res.peak_to_peak), .o_mean_square(dut_res.mean_square),
        .o_rms_level(dut_res.rms_level), .o_edge_count(dut_res.edge_count),
        .o_high_time_avg(dut_res.high_time_avg), .o_low_time_avg(dut_res.low_time_avg),
        .o_rise_position(dut_res.rise_position), .o_fall_position(dut_res.fall_position)
    );

    // Transfer monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) sb.note_sample(i_sample, i_last_sample);
            if (pop && !empty) sb.check_result(dut_res);
        end
    end

    // Receiver: a randomly chosen stall pattern in turn, plus a long hold-off on request
    initial begin
        int unsigned mode;
        pop <= 1'b0;
        forever begin
            mode = $urandom_range(0, 2);
            for (int c = 0; c < 64; c++) begin
                if (hold_req) begin
                    pop <= 1'b0;
                    for (int h = 0; h < 1500; h++) @(posedge i_clk);
                    hold_req = 1'b0;
                end
                case (mode)
                    0: pop <= 1'b1;
                    1: pop <= ($urandom_range(0, 1) == 0);
                    default: pop <= ($urandom_range(0, 9) == 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    // Setup and access phases, then idle before the next write
    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge i_clk);
    endtask

    task automatic send_sample(logic [11:0] s, logic last);
        push <= 1'b1;
        i_sample <= s;
        i_last_sample <= last;
        do @(posedge i_clk); while (full);
    endtask

    task automatic idle_cycles(int unsigned n);
        if (n == 0) return;
        push <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Hold off input until every expected measurement has come out
    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (sb.measurements.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_levels(logic [11:0] up, logic [11:0] lo, logic [11:0] ctr,
                              logic [12:0] pre);
        drain();
        reg_write(REG_UPPER, up);
        reg_write(REG_LOWER, lo);
        reg_write(REG_CENTRE, ctr);
        reg_write(REG_PRETRIG, pre);
    endtask

    function automatic logic [11:0] pick_level(bit want_high);
        if ($urandom_range(0, 7) == 0) return 12'($urandom_range(0, 4095));
        if (want_high)
            return (sb.upper_thr < 12'hFFF) ?
                12'($urandom_range(sb.upper_thr + 1, 4095)) : 12'hFFF;
        return (sb.lower_thr > 0) ? 12'($urandom_range(0, sb.lower_thr - 1)) : 12'd0;
    endfunction

    // One capture: a square-ish wave of random duty, random gaps in bursts
    task automatic send_capture(int unsigned len, bit bursty);
        bit hi;
        int unsigned run, burst;
        hi = $urandom_range(0, 1);
        run = $urandom_range(1, 6);
        burst = $urandom_range(1, 12);
        for (int unsigned k = 0; k < len; k++) begin
            send_sample(pick_level(hi), k == len - 1);
            if (--run == 0) begin
                hi = !hi;
                run = $urandom_range(1, 6);
            end
            if (bursty && --burst == 0) begin
                idle_cycles($urandom_range(1, 8));
                burst = $urandom_range(1, 12);
            end
        end
    endtask

    task automatic random_phase(int unsigned n_items);
        int unsigned sent, len;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200)
                                              : $urandom_range(1, 25);
            send_capture(len, $urandom_range(0, 3) != 0);
            sent += len;
        end
    endtask

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        sb = new();
        i_rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        push <= 1'b0;
        i_sample <= '0;
        i_last_sample <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        // Directed: single-sample capture, extremes, no edges, edges both ways
        send_sample(12'hFFF, 1'b1);
        send_sample(12'h000, 1'b1);
        send_sample(12'd2048, 1'b0);
        send_sample(12'd2000, 1'b1);
        for (int k = 0; k < 8; k++) send_sample((k % 2) ? 12'hFFF : 12'h000, k == 7);
        idle_cycles(3);
        for (int k = 0; k < 6; k++) send_sample((k / 2 % 2) ? 12'd100 : 12'd4000, k == 5);

        // Crossed thresholds, pretrigger zero, centre at full scale
        set_levels(12'd1000, 12'd3000, 12'hFFF, 13'd0);
        for (int k = 0; k < 6; k++) send_sample((k % 2) ? 12'd2000 : 12'd500, k == 5);

        // Pretrigger at the top of the index range
        set_levels(12'd2148, 12'd1948, 12'd2048, 13'd8191);
        for (int unsigned k = 0; k < 60; k++)
            send_sample(((k / 3) % 2) ? 12'd3500 : 12'd300, k == 59);

        // Random phases over several register settings
        set_levels(UPPER_RST, LOWER_RST, CENTRE_RST, PRETRIG_RST);
        random_phase(180);
        set_levels(12'hFFF, 12'h000, 12'h000, 13'd0);
        random_phase(120);
        set_levels(12'd2500, 12'd1500, 12'd2048, 13'd10);
        random_phase(180);
        set_levels(12'd1000, 12'd3000, 12'hFFF, 13'h1FFF);
        random_phase(120);

        // Long receiver hold-off while short captures keep arriving
        drain();
        hold_req = 1'b1;
        for (int k = 0; k < 10; k++) send_capture(3, 1'b0);

        set_levels(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                   12'($urandom_range(0, 4095)), 13'($urandom_range(1, 40)));
        random_phase(200);

        drain();
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
